// ----- rtl/core/csmv_pkg.sv -----
// types and constants shared by the csr sparse matrix vector multiply block
// transaction structs for both channels, op codes for the internal queue
// no dependencies
package csmv_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam logic [15:0] ROW_COUNT_RESET = 16'd4;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_NZ   = 2'd1,
		MODE_END  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_MAC  = 2'd1,
		OP_END  = 2'd2
	} op_kind_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         index;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic signed [63:0] row_sum;
		logic [15:0]        row_number;
		logic               last_row;
	} result_t;

	typedef struct packed {
		op_kind_t           kind;
		logic               zero;
		logic [7:0]         index;
		logic signed [31:0] value;
	} op_t;

endpackage

// ----- rtl/core/csmv_front.sv -----
// front end: accepts input transactions and classifies them into queue ops
// drops unused modes and out-of-range loads, flags out-of-range reads
// depends on csmv_pkg
module csmv_front import csmv_pkg::*; #(
	parameter int unsigned VECTOR_DEPTH = 256
) (
	input  item_t item,
	input  logic  item_valid,
	input  logic  queue_full,
	output logic  item_stall,
	output logic  push,
	output op_t   push_op
);

	logic in_range;
	logic keep;

	assign in_range   = {9'd0, item.index} < 17'(VECTOR_DEPTH);
	assign item_stall = queue_full;

	always_comb begin
		keep          = 1'b0;
		push_op.kind  = OP_LOAD;
		push_op.zero  = !in_range;
		push_op.index = item.index;
		push_op.value = item.value;
		case (item.mode)
			MODE_LOAD: begin
				keep         = in_range;
				push_op.kind = OP_LOAD;
			end
			MODE_NZ: begin
				keep         = 1'b1;
				push_op.kind = OP_MAC;
			end
			MODE_END: begin
				keep         = 1'b1;
				push_op.kind = OP_END;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = item_valid && !item_stall && keep;

endmodule

// ----- rtl/core/csmv_queue.sv -----
// short queue of classified ops between front and back end
// register array with head and tail pointers
// depends on csmv_pkg
module csmv_queue import csmv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output op_t  head_op
);

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head_op   = entry_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/csmv_back.sv -----
// back end: vector store, multiplier and saturating row accumulator
// stage 1 reads or writes the store, stage 2 holds the product, then accumulate or emit
// depends on csmv_pkg
module csmv_back import csmv_pkg::*; #(
	parameter int unsigned VECTOR_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        not_empty,
	input  op_t         head_op,
	output logic        pop,
	input  logic [15:0] row_count,
	input  logic        result_stall,
	output logic        result_valid,
	output result_t     result
);

	localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

	logic [31:0]        mem [VECTOR_DEPTH];
	logic [AW-1:0]      addr;
	logic signed [31:0] rd_s1;
	logic               valid_s1;
	op_kind_t           kind_s1;
	logic               zero_s1;
	logic signed [31:0] value_s1;
	logic               valid_s2;
	op_kind_t           kind_s2;
	logic signed [63:0] prod_s2;
	logic signed [63:0] acc_q;
	logic [15:0]        row_counter_q;
	logic               result_valid_q;
	result_t            result_q;
	logic               hold;
	logic signed [31:0] operand;
	logic signed [64:0] sum;
	logic signed [63:0] sum_sat;
	logic [16:0]        next_row;
	logic               last;

	assign addr    = AW'(head_op.index);
	assign hold    = valid_s2 && (kind_s2 == OP_END) && result_valid_q && result_stall;
	assign pop     = not_empty && !hold;
	assign operand = zero_s1 ? 32'sd0 : rd_s1;

	assign sum = {acc_q[63], acc_q} + {prod_s2[63], prod_s2};
	always_comb begin
		if (sum[64] != sum[63]) begin
			sum_sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sum_sat = sum[63:0];
		end
	end

	assign next_row = {1'b0, row_counter_q} + 17'd1;
	assign last     = next_row >= {1'b0, row_count};

	// vector store
	always_ff @(posedge clk) begin
		if (pop) begin
			if (head_op.kind == OP_LOAD) begin
				mem[addr] <= head_op.value;
			end
			rd_s1 <= mem[addr];
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1  <= head_op.kind;
			zero_s1  <= head_op.zero;
			value_s1 <= head_op.value;
		end
		if (!hold) begin
			kind_s2 <= kind_s1;
			prod_s2 <= value_s1 * operand;
		end
		if (valid_s2 && !hold && kind_s2 == OP_END) begin
			result_q.row_sum    <= acc_q;
			result_q.row_number <= row_counter_q;
			result_q.last_row   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			acc_q          <= '0;
			row_counter_q  <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (!hold) begin
				valid_s1 <= pop;
				valid_s2 <= valid_s1;
			end
			if (valid_s2 && !hold) begin
				case (kind_s2)
					OP_MAC: begin
						acc_q <= sum_sat;
					end
					OP_END: begin
						acc_q         <= '0;
						row_counter_q <= last ? 16'd0 : next_row[15:0];
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
			if (valid_s2 && !hold && kind_s2 == OP_END) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/core/csr_sparse_matrix_vector_multiply.sv -----
// top level of the csr sparse matrix vector multiply block
// instantiates csmv_front, csmv_queue and csmv_back; holds the row_count register
// depends on csmv_pkg
//
// usage:
// input transactions (item, item_valid, item_stall) carry mode, index and value.
// mode 0 loads a dense vector element, mode 1 a nonzero entry with its column,
// mode 2 closes a row and produces one result transaction; mode 3 is dropped.
// result transactions (result, result_valid, result_stall) carry the saturated
// Q32.32 row sum, the row number and a last-row flag.
// cfg_valid/cfg_ready/cfg_data writes row_count; cfg_ready is always high,
// and writes must be made only while the block is idle; the block itself does
// not enforce this. one input transaction per cycle is sustained while
// item_stall is low; the multiply-accumulate stage retires one op per clock
// unless a stalled result holds it. a row end passes the queue, store read,
// product register and result register. a stalled result holds the back end;
// the 4-entry queue keeps taking input until it fills, then item_stall rises.
// reset clears the queue, pipeline, accumulator and row counter and sets
// row_count to 4; the vector store is not cleared.
module csr_sparse_matrix_vector_multiply import csmv_pkg::*; #(
	parameter int unsigned VECTOR_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        item_valid,
	output logic        item_stall,
	output result_t     result,
	output logic        result_valid,
	input  logic        result_stall,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        push;
	op_t         push_op;
	logic        pop;
	logic        full;
	logic        not_empty;
	op_t         head_op;
	logic [15:0] row_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			row_count_q <= cfg_data;
		end
	end

	csmv_front #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_front (
		.item      (item),
		.item_valid(item_valid),
		.queue_full(full),
		.item_stall(item_stall),
		.push      (push),
		.push_op   (push_op)
	);

	csmv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.pop      (pop),
		.full     (full),
		.not_empty(not_empty),
		.head_op  (head_op)
	);

	csmv_back #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.not_empty   (not_empty),
		.head_op     (head_op),
		.pop         (pop),
		.row_count   (row_count_q),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule
